[rtl/ddet_pkg.sv]
// Package for the deadlock detector: sizes, item structs, kind codes and
// the control/status structs passed between the sweep modules.
// No dependencies.
`default_nettype none

package ddet_pkg;

	localparam int NUM_PROCS = 8;
	localparam int NUM_RES   = 4;

	localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int RES_W  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;

	localparam int VAL_W  = 8;
	localparam int WORK_W = 16;
	// one lane per resource: {alloc, request}
	localparam int LANE_W = 2 * VAL_W;
	localparam int ROW_W  = NUM_RES * LANE_W;

	localparam logic [1:0] KIND_LOAD_PROC  = 2'd0;
	localparam logic [1:0] KIND_LOAD_AVAIL = 2'd1;
	localparam logic [1:0] KIND_RUN        = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] proc_index;
		logic [3:0] res_index;
		logic [7:0] alloc_value;
		logic [7:0] request_value;
		logic [7:0] avail_value;
	} cmd_t;

	typedef struct packed {
		logic [5:0] process_id;
		logic       deadlocked;
		logic       any_deadlock;
		logic       last;
	} rpt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic              eval;
		logic [PROC_W-1:0] proc;
		logic              avail_we;
		logic [RES_W-1:0]  avail_res;
		logic [VAL_W-1:0]  avail_val;
	} ctrl_t;

	typedef struct packed {
		logic release_hit;
	} stat_t;

endpackage

`default_nettype wire

[rtl/ddet_ram.sv]
// Generic single-write, single-read synchronous RAM with lane write enables.
// Registered read data. No dependencies.
`default_nettype none

module ddet_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	parameter int LANES = 4
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [LANES-1:0]                        wlane,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	localparam int LW = WIDTH / LANES;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int l = 0; l < LANES; l++) begin
				if (wlane[l]) begin
					mem[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/ddet_eval.sv]
// Evaluation stage: available vector, work vector and finished flags.
// Compares a process row against work and releases its allocation.
// Depends on ddet_pkg.
`default_nettype none

module ddet_eval (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ddet_pkg::ctrl_t             ctrl,
	input  wire logic [ddet_pkg::ROW_W-1:0]  row,
	output ddet_pkg::stat_t                  stat,
	output logic [ddet_pkg::NUM_PROCS-1:0]   finished
);

	logic [ddet_pkg::VAL_W-1:0]  avail_q [ddet_pkg::NUM_RES];
	logic [ddet_pkg::WORK_W-1:0] work_q  [ddet_pkg::NUM_RES];
	logic [ddet_pkg::WORK_W-1:0] work_d  [ddet_pkg::NUM_RES];
	logic [ddet_pkg::WORK_W:0]   sum     [ddet_pkg::NUM_RES];
	logic [ddet_pkg::NUM_RES-1:0] fits;
	logic [ddet_pkg::NUM_PROCS-1:0] fin_q;
	logic hit;

	always_comb begin
		for (int r = 0; r < ddet_pkg::NUM_RES; r++) begin
			fits[r] = ddet_pkg::WORK_W'(row[r*ddet_pkg::LANE_W +: ddet_pkg::VAL_W])
				<= work_q[r];
			sum[r] = {1'b0, work_q[r]} + (ddet_pkg::WORK_W + 1)'(
				row[r*ddet_pkg::LANE_W + ddet_pkg::VAL_W +: ddet_pkg::VAL_W]);
			// saturate at the register width
			work_d[r] = sum[r][ddet_pkg::WORK_W] ? '1 : sum[r][ddet_pkg::WORK_W-1:0];
		end
	end

	assign hit = ctrl.eval && !fin_q[ctrl.proc] && (&fits);
	assign stat.release_hit = hit;
	assign finished = fin_q;

	always_ff @(posedge clk) begin
		if (ctrl.avail_we) begin
			avail_q[ctrl.avail_res] <= ctrl.avail_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ddet_pkg::NUM_RES; r++) begin
				work_q[r] <= '0;
			end
			fin_q <= '0;
		end else if (ctrl.start) begin
			for (int r = 0; r < ddet_pkg::NUM_RES; r++) begin
				work_q[r] <= ddet_pkg::WORK_W'(avail_q[r]);
			end
			fin_q <= '0;
		end else if (hit) begin
			for (int r = 0; r < ddet_pkg::NUM_RES; r++) begin
				work_q[r] <= work_d[r];
			end
			fin_q[ctrl.proc] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/deadlock_detector_unit.sv]
// Deadlock detector top level: command decode, sweep sequencer, result
// register. Depends on ddet_pkg, ddet_ram, ddet_eval.
//
//   channel | direction | payload           | handshake
//   cmd     | in        | ddet_pkg::cmd_t   | cmd_valid / cmd_ready
//   rpt     | out       | ddet_pkg::rpt_t   | rpt_valid / rpt_ready
//
// Load items are accepted back to back while the unit is idle.
// A run item sweeps the processes in passes, ending with a final pass that
// releases nobody: the row memory is read one process per
// cycle, pipelined with the compare/release stage, then NUM_PROCS result
// items leave through the output register.
// cmd_ready is low from the run item until its last result is loaded.
// No clearing pass after reset; a stalled rpt_ready holds the result register.
`default_nettype none

module deadlock_detector_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire ddet_pkg::cmd_t cmd,
	output logic                rpt_valid,
	input  wire logic           rpt_ready,
	output ddet_pkg::rpt_t      rpt
);

	localparam int PW = ddet_pkg::PROC_W;
	localparam logic [PW-1:0] LAST_PROC = PW'(ddet_pkg::NUM_PROCS - 1);

	ddet_pkg::state_t state_q, state_d;
	ddet_pkg::ctrl_t  ctrl;
	ddet_pkg::stat_t  stat;

	logic [PW-1:0] issue_q;
	logic [PW-1:0] proc_s1;
	logic          valid_s1;
	logic          progress_q;
	logic [PW-1:0] emit_q;
	logic          rpt_valid_q;
	ddet_pkg::rpt_t rpt_q;

	logic [ddet_pkg::ROW_W-1:0]     row;
	logic [ddet_pkg::NUM_PROCS-1:0] finished;
	logic accept, is_run, proc_ok, res_ok, mem_we;
	logic last_s1, stop, slot_free, emit_last, emit_load;
	logic [ddet_pkg::NUM_RES-1:0] wlane;

	assign accept  = cmd_valid && cmd_ready;
	assign is_run  = cmd.kind == ddet_pkg::KIND_RUN;
	assign proc_ok = {1'b0, cmd.proc_index} < 7'(ddet_pkg::NUM_PROCS);
	assign res_ok  = {1'b0, cmd.res_index} < 5'(ddet_pkg::NUM_RES);
	assign mem_we  = accept && cmd.kind == ddet_pkg::KIND_LOAD_PROC && proc_ok && res_ok;
	assign wlane   = ddet_pkg::NUM_RES'(1) << cmd.res_index[ddet_pkg::RES_W-1:0];

	assign last_s1   = valid_s1 && proc_s1 == LAST_PROC;
	// a full pass that released nobody ends the run
	assign stop      = last_s1 && !(progress_q || stat.release_hit);
	assign slot_free = !rpt_valid_q || rpt_ready;
	assign emit_last = emit_q == LAST_PROC;
	assign emit_load = state_q == ddet_pkg::ST_EMIT && slot_free;

	always_comb begin
		ctrl.start     = accept && is_run;
		ctrl.eval      = valid_s1;
		ctrl.proc      = proc_s1;
		ctrl.avail_we  = accept && cmd.kind == ddet_pkg::KIND_LOAD_AVAIL && res_ok;
		ctrl.avail_res = cmd.res_index[ddet_pkg::RES_W-1:0];
		ctrl.avail_val = cmd.avail_value;
	end

	ddet_ram #(
		.WIDTH(ddet_pkg::ROW_W),
		.DEPTH(ddet_pkg::NUM_PROCS),
		.LANES(ddet_pkg::NUM_RES)
	) u_rows (
		.clk   (clk),
		.we    (mem_we),
		.wlane (wlane),
		.waddr (cmd.proc_index[PW-1:0]),
		.wdata ({ddet_pkg::NUM_RES{cmd.alloc_value, cmd.request_value}}),
		.re    (state_q == ddet_pkg::ST_SWEEP),
		.raddr (issue_q),
		.rdata (row)
	);

	ddet_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.row      (row),
		.stat     (stat),
		.finished (finished)
	);

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			ddet_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (accept && is_run) begin
					state_d = ddet_pkg::ST_SWEEP;
				end
			end
			ddet_pkg::ST_SWEEP: begin
				if (stop) begin
					state_d = ddet_pkg::ST_EMIT;
				end
			end
			ddet_pkg::ST_EMIT: begin
				if (slot_free && emit_last) begin
					state_d = ddet_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ddet_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ddet_pkg::ST_IDLE;
			issue_q     <= '0;
			proc_s1     <= '0;
			valid_s1    <= 1'b0;
			progress_q  <= 1'b0;
			emit_q      <= '0;
			rpt_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= state_q == ddet_pkg::ST_SWEEP && !stop;
			proc_s1  <= issue_q;
			if (ctrl.start) begin
				issue_q    <= '0;
				progress_q <= 1'b0;
				emit_q     <= '0;
			end else begin
				if (state_q == ddet_pkg::ST_SWEEP) begin
					issue_q <= (issue_q == LAST_PROC) ? '0 : issue_q + 1'b1;
				end
				if (last_s1) begin
					progress_q <= 1'b0;
				end else if (stat.release_hit) begin
					progress_q <= 1'b1;
				end
				if (emit_load) begin
					emit_q <= emit_q + 1'b1;
				end
			end
			if (slot_free) begin
				rpt_valid_q <= state_q == ddet_pkg::ST_EMIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rpt_q.process_id   <= 6'(emit_q);
			rpt_q.deadlocked   <= !finished[emit_q];
			rpt_q.any_deadlock <= emit_last && !(&finished);
			rpt_q.last         <= emit_last;
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

endmodule

`default_nettype wire

[rtl/ddet_checker.sv]
// Port-level checker for deadlock_detector_unit, attached by bind.
// Depends on ddet_pkg.
`default_nettype none

module ddet_props (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_ready,
	input wire ddet_pkg::cmd_t cmd,
	input wire logic           rpt_valid,
	input wire logic           rpt_ready,
	input wire ddet_pkg::rpt_t rpt
);

	// a stalled result item holds
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid && $stable(rpt))
		else $error("result item changed while stalled");

	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt.last |-> rpt.process_id == 6'(ddet_pkg::NUM_PROCS - 1))
		else $error("last marker on wrong process");

	a_any_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt.any_deadlock |-> rpt.last)
		else $error("summary flag away from last item");

	a_summary: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rpt.last && rpt.deadlocked |-> rpt.any_deadlock)
		else $error("deadlocked last process without summary flag");

	// input closes while a run sweeps
	a_run_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.kind == ddet_pkg::KIND_RUN |=> !cmd_ready)
		else $error("input open straight after a run item");

endmodule

bind deadlock_detector_unit ddet_props u_ddet_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.rpt_valid (rpt_valid),
	.rpt_ready (rpt_ready),
	.rpt       (rpt)
);

`default_nettype wire
